>>> rtl/core/fesg_pkg.sv
package fesg_pkg;

    // Default build values
    localparam int TICK_US_DEF      = 20000;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int PHASE_BITS_DEF   = 32;

    // Field and datapath widths
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CS_W       = 32;
    localparam int RATE_W     = 21;
    localparam int AMP_W      = 24;
    localparam int ALT_W      = 24;
    localparam int HDG_W      = 19;
    localparam int THR_W      = 16;
    localparam int CNT_W      = 16;
    localparam int TICKS_W    = 8;
    localparam int POS_W      = 25;
    localparam int VEL_W      = 29;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int RND_W      = PROD_W - 30;
    localparam int ANGLE_N    = 24;
    localparam int ANGLE_IDX_W = 5;

    // 2^48 / (2*pi*1e6): rad/s * us into 2^-48 turn
    localparam int K48_W = 26;
    localparam logic [K48_W-1:0] K48 = 26'd44798134;
    localparam int LO_SH = 20;

    // CORDIC start value, 0.60725293 in Q2.30
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // Output clamp limits
    localparam logic signed [RND_W-1:0] POSX_LIM = 34'sd16777215;
    localparam logic signed [RND_W-1:0] POSY_LIM = 34'sd8388608;
    localparam logic signed [RND_W-1:0] VEL_LIM  = 34'sd167772160;

    // Register reset values
    localparam logic [AMP_W-1:0]         AMP_RST  = 24'd327680;
    localparam logic signed [RATE_W-1:0] RATE_RST = 21'sd32768;
    localparam logic signed [ALT_W-1:0]  ALT_RST  = -24'sd327680;
    localparam logic signed [HDG_W-1:0]  HDG_RST  = 19'sd0;
    localparam logic [THR_W-1:0]         THR_RST  = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AMPLITUDE     = 3'd0,
        CFG_ANGULAR_RATE  = 3'd1,
        CFG_ALTITUDE      = 3'd2,
        CFG_HEADING       = 3'd3,
        CFG_ARM_THRESHOLD = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_HI,
        ST_LO,
        ST_SUM,
        ST_RND,
        ST_STEP,
        ST_PHASE,
        ST_TRIG,
        ST_WAIT,
        ST_AW,
        ST_SC,
        ST_CC,
        ST_SS,
        ST_PX,
        ST_PY,
        ST_VX,
        ST_VY,
        ST_LAST,
        ST_DONE
    } t_state;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [CS_W-1:0] f_atan_turns(input logic [ANGLE_IDX_W-1:0] idx);
        logic [CS_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/fesg_mul.sv
module fesg_mul
    import fesg_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/fesg_cordic.sv
module fesg_cordic
    import fesg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int PHASE_BITS   = PHASE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [PHASE_BITS-1:0]  i_phase,
    output logic                   o_done,
    output logic signed [CS_W-1:0] o_sin,
    output logic signed [CS_W-1:0] o_cos
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    logic [CS_W-1:0]        p32;
    logic [CS_W-1:0]        p_bias;
    logic [1:0]             quad;
    logic [CS_W-1:0]        resid;

    logic                   r_busy;
    logic                   r_fin;
    logic                   r_done;
    logic [STEP_W-1:0]      r_step;
    logic [1:0]             r_quad;
    logic signed [CS_W-1:0] r_x;
    logic signed [CS_W-1:0] r_y;
    logic signed [CS_W-1:0] r_z;
    logic signed [CS_W-1:0] r_sin;
    logic signed [CS_W-1:0] r_cos;

    logic signed [CS_W-1:0] n_x;
    logic signed [CS_W-1:0] n_y;
    logic signed [CS_W-1:0] n_z;
    logic signed [CS_W-1:0] sh_x;
    logic signed [CS_W-1:0] sh_y;
    logic signed [CS_W-1:0] ang;
    logic                   last_step;

    // Fold to the nearest quadrant; rotate only the residual
    assign p32    = CS_W'(i_phase) << (CS_W - PHASE_BITS);
    assign p_bias = p32 + 32'h2000_0000;
    assign quad   = p_bias[CS_W-1 -: 2];
    assign resid  = p32 - {quad, {(CS_W-2){1'b0}}};

    assign sh_x      = r_x >>> r_step;
    assign sh_y      = r_y >>> r_step;
    assign ang       = $signed(f_atan_turns(ANGLE_IDX_W'(r_step)));
    assign last_step = (r_step == STEP_W'(CORDIC_STEPS - 1));

    always_comb begin
        if (!r_z[CS_W-1]) begin
            n_x = r_x - sh_y;
            n_y = r_y + sh_x;
            n_z = r_z - ang;
        end else begin
            n_x = r_x + sh_y;
            n_y = r_y - sh_x;
            n_z = r_z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= $signed(resid);
            r_quad <= quad;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
        // Unfold the quadrant after the last rotation
        if (r_fin) begin
            case (r_quad)
                2'd0: begin
                    r_sin <= r_y;
                    r_cos <= r_x;
                end
                2'd1: begin
                    r_sin <= r_x;
                    r_cos <= -r_y;
                end
                2'd2: begin
                    r_sin <= -r_y;
                    r_cos <= -r_x;
                end
                default: begin
                    r_sin <= -r_x;
                    r_cos <= r_y;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

>>> rtl/core/figure_eight_setpoint_generator.sv
// Figure-eight (lemniscate of Gerono) setpoint generator.
// Input channel: one request per control tick carrying ticks_elapsed, the
// number of tick periods since the previous request. The phase advances by
// angular_rate * TICK_US * ticks_elapsed and one setpoint comes out: position
// x/y and velocity x/y (all saturated), altitude and heading from the registers,
// and arm_request, high on exactly one setpoint once the emitted count has
// reached arm_threshold. All values are signed Q16.16.
// Configuration channel: index/data writes, always ready; write only while
// no request is in flight.
// Each request runs the phase products, the CORDIC iterations and then the
// sequence of products through the single 32x32 multiplier. The input is
// ready again the cycle after the result is loaded into the output register,
// so a new request is taken only once the last one has been computed.
// A finished setpoint waits in the output register; the next request is taken
// meanwhile, and its result holds in the last step until the output is free.
// Reset restores the register defaults and clears phase, count and arm flag.
module figure_eight_setpoint_generator
    import fesg_pkg::*;
#(
    parameter int TICK_US      = TICK_US_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int PHASE_BITS   = PHASE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [TICKS_W-1:0]      i_ticks_elapsed,

    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic signed [ALT_W-1:0] o_pos_z,
    output logic signed [VEL_W-1:0] o_vel_x,
    output logic signed [VEL_W-1:0] o_vel_y,
    output logic signed [HDG_W-1:0] o_yaw_out,
    output logic                    o_arm_request,

    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int TICK_W  = $clog2(TICK_US + 1);
    localparam int M_W     = RATE_W + TICK_W;
    localparam int LOP_W   = LO_SH + K48_W;
    localparam int HI_W    = M_W - LO_SH + K48_W;
    localparam int A_W     = HI_W + 1;
    localparam int RND_SH  = PROD_W - PHASE_BITS - LO_SH;

    localparam logic [A_W:0] INC_BIAS = (A_W + 1)'(1) << (RND_SH - 1);

    t_state                  r_state, n_state;

    logic [AMP_W-1:0]         r_amp;
    logic signed [RATE_W-1:0] r_rate;
    logic signed [ALT_W-1:0]  r_alt;
    logic signed [HDG_W-1:0]  r_hdg;
    logic [THR_W-1:0]         r_thr;

    logic [TICKS_W-1:0]       r_ticks;
    logic [PHASE_BITS-1:0]    r_phase;
    logic [PHASE_BITS-1:0]    n_phase;
    logic [CNT_W-1:0]         r_count;
    logic                     r_arm_done;

    logic [M_W-1:0]           r_m;
    logic [HI_W-1:0]          r_hi;
    logic [A_W-1:0]           r_a;
    logic [A_W:0]             a_bias;
    logic [PHASE_BITS-1:0]    r_inc;

    logic signed [CS_W-1:0]   r_aw;
    logic signed [CS_W-1:0]   r_sc;
    logic signed [CS_W-1:0]   r_cc;
    logic signed [CS_W-1:0]   r_ss;
    logic signed [CS_W-1:0]   r_c2;
    logic signed [POS_W-1:0]  r_px;
    logic signed [POS_W-1:0]  r_py;
    logic signed [VEL_W-1:0]  r_vx;
    logic signed [VEL_W-1:0]  r_vy;

    logic                     r_out_valid;
    logic signed [POS_W-1:0]  r_o_pos_x;
    logic signed [POS_W-1:0]  r_o_pos_y;
    logic signed [ALT_W-1:0]  r_o_pos_z;
    logic signed [VEL_W-1:0]  r_o_vel_x;
    logic signed [VEL_W-1:0]  r_o_vel_y;
    logic signed [HDG_W-1:0]  r_o_yaw;
    logic                     r_o_arm;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] sum30;
    logic signed [PROD_W-1:0] sum16;
    logic signed [RND_W-1:0]  rnd30;

    logic                     rate_neg;
    logic [RATE_W-1:0]        rate_mag;
    logic                     cs_start;
    logic                     cs_done;
    logic signed [CS_W-1:0]   cs_sin;
    logic signed [CS_W-1:0]   cs_cos;
    logic                     load_out;
    logic                     arm_now;

    function automatic logic signed [RND_W-1:0] f_clamp(
        input logic signed [RND_W-1:0] v,
        input logic signed [RND_W-1:0] lim
    );
        logic signed [RND_W-1:0] r;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

    fesg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    fesg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .PHASE_BITS   (PHASE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cs_start),
        .i_phase (r_phase),
        .o_done  (cs_done),
        .o_sin   (cs_sin),
        .o_cos   (cs_cos)
    );

    // The magnitude of the most negative rate reads correctly as unsigned
    assign rate_neg = r_rate[RATE_W-1];
    assign rate_mag = rate_neg ? RATE_W'(-r_rate) : RATE_W'(r_rate);

    // Round half up on product shifts
    assign sum30 = prod + (PROD_W'(1) <<< 29);
    assign sum16 = prod + (PROD_W'(1) <<< 15);
    assign rnd30 = $signed(sum30[PROD_W-1:30]);

    assign a_bias  = (A_W + 1)'(r_a) + INC_BIAS;
    assign n_phase = rate_neg ? r_phase - prod[PHASE_BITS-1:0]
                              : r_phase + prod[PHASE_BITS-1:0];

    assign cs_start = (r_state == ST_TRIG);
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign arm_now  = !r_arm_done && (r_count >= r_thr);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RATE;
                end
            end
            ST_RATE: begin
                mul_a   = MUL_W'(rate_mag);
                mul_b   = MUL_W'(TICK_US);
                n_state = ST_HI;
            end
            ST_HI: begin
                mul_a   = MUL_W'(prod[M_W-1:LO_SH]);
                mul_b   = MUL_W'(K48);
                n_state = ST_LO;
            end
            ST_LO: begin
                mul_a   = MUL_W'(r_m[LO_SH-1:0]);
                mul_b   = MUL_W'(K48);
                n_state = ST_SUM;
            end
            ST_SUM:   n_state = ST_RND;
            ST_RND:   n_state = ST_STEP;
            ST_STEP: begin
                mul_a   = $signed(MUL_W'(r_inc));
                mul_b   = MUL_W'(r_ticks);
                n_state = ST_PHASE;
            end
            ST_PHASE: n_state = ST_TRIG;
            ST_TRIG:  n_state = ST_WAIT;
            ST_WAIT: begin
                if (cs_done) begin
                    n_state = ST_AW;
                end
            end
            ST_AW: begin
                mul_a   = MUL_W'(r_amp);
                mul_b   = MUL_W'(r_rate);
                n_state = ST_SC;
            end
            ST_SC: begin
                mul_a   = cs_sin;
                mul_b   = cs_cos;
                n_state = ST_CC;
            end
            ST_CC: begin
                mul_a   = cs_cos;
                mul_b   = cs_cos;
                n_state = ST_SS;
            end
            ST_SS: begin
                mul_a   = cs_sin;
                mul_b   = cs_sin;
                n_state = ST_PX;
            end
            ST_PX: begin
                mul_a   = MUL_W'(r_amp);
                mul_b   = cs_sin;
                n_state = ST_PY;
            end
            ST_PY: begin
                mul_a   = MUL_W'(r_amp);
                mul_b   = r_sc;
                n_state = ST_VX;
            end
            ST_VX: begin
                mul_a   = r_aw;
                mul_b   = cs_cos;
                n_state = ST_VY;
            end
            ST_VY: begin
                mul_a   = r_aw;
                mul_b   = r_c2;
                n_state = ST_LAST;
            end
            ST_LAST:  n_state = ST_DONE;
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_amp       <= AMP_RST;
            r_rate      <= RATE_RST;
            r_alt       <= ALT_RST;
            r_hdg       <= HDG_RST;
            r_thr       <= THR_RST;
            r_phase     <= '0;
            r_count     <= '0;
            r_arm_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_AMPLITUDE:     r_amp  <= AMP_W'(i_cfg_data);
                    CFG_ANGULAR_RATE:  r_rate <= $signed(RATE_W'(i_cfg_data));
                    CFG_ALTITUDE:      r_alt  <= $signed(ALT_W'(i_cfg_data));
                    CFG_HEADING:       r_hdg  <= $signed(HDG_W'(i_cfg_data));
                    CFG_ARM_THRESHOLD: r_thr  <= THR_W'(i_cfg_data);
                    default: ;
                endcase
            end
            if (r_state == ST_PHASE) begin
                r_phase <= n_phase;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
                if (arm_now) begin
                    r_arm_done <= 1'b1;
                end
                // Saturate the emitted count
                if (r_count != {CNT_W{1'b1}}) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE:  r_ticks <= i_ticks_elapsed;
            ST_HI:    r_m     <= prod[M_W-1:0];
            ST_LO:    r_hi    <= prod[HI_W-1:0];
            ST_SUM:   r_a     <= A_W'(r_hi) + A_W'(prod[LOP_W-1:LO_SH]);
            ST_RND:   r_inc   <= PHASE_BITS'(a_bias >> RND_SH);
            ST_SC:    r_aw    <= $signed(sum16[CS_W+15:16]);
            ST_CC:    r_sc    <= CS_W'(rnd30);
            ST_SS:    r_cc    <= CS_W'(rnd30);
            ST_PX:    r_ss    <= CS_W'(rnd30);
            ST_PY: begin
                r_px <= POS_W'(f_clamp(rnd30, POSX_LIM));
                r_c2 <= r_cc - r_ss;
            end
            ST_VX:    r_py    <= POS_W'(f_clamp(rnd30, POSY_LIM));
            ST_VY:    r_vx    <= VEL_W'(f_clamp(rnd30, VEL_LIM));
            ST_LAST:  r_vy    <= VEL_W'(f_clamp(rnd30, VEL_LIM));
            default: ;
        endcase
        if (load_out) begin
            r_o_pos_x <= r_px;
            r_o_pos_y <= r_py;
            r_o_pos_z <= r_alt;
            r_o_vel_x <= r_vx;
            r_o_vel_y <= r_vy;
            r_o_yaw   <= r_hdg;
            r_o_arm   <= arm_now;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_o_pos_x;
    assign o_pos_y       = r_o_pos_y;
    assign o_pos_z       = r_o_pos_z;
    assign o_vel_x       = r_o_vel_x;
    assign o_vel_y       = r_o_vel_y;
    assign o_yaw_out     = r_o_yaw;
    assign o_arm_request = r_o_arm;

endmodule
